// File: rtl/core/wia_pkg.sv
package wia_pkg;

    localparam int DATA_W = 64;
    localparam int ACT_W  = 5;
    localparam int TRAP_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [ACT_W-1:0] ACT_EQZ    = 5'd0;
    localparam logic [ACT_W-1:0] ACT_EQ     = 5'd1;
    localparam logic [ACT_W-1:0] ACT_NE     = 5'd2;
    localparam logic [ACT_W-1:0] ACT_LT_S   = 5'd3;
    localparam logic [ACT_W-1:0] ACT_GT_S   = 5'd4;
    localparam logic [ACT_W-1:0] ACT_LE_S   = 5'd5;
    localparam logic [ACT_W-1:0] ACT_GE_S   = 5'd6;
    localparam logic [ACT_W-1:0] ACT_LT_U   = 5'd7;
    localparam logic [ACT_W-1:0] ACT_GT_U   = 5'd8;
    localparam logic [ACT_W-1:0] ACT_LE_U   = 5'd9;
    localparam logic [ACT_W-1:0] ACT_GE_U   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_CLZ    = 5'd11;
    localparam logic [ACT_W-1:0] ACT_CTZ    = 5'd12;
    localparam logic [ACT_W-1:0] ACT_POPCNT = 5'd13;
    localparam logic [ACT_W-1:0] ACT_ADD    = 5'd14;
    localparam logic [ACT_W-1:0] ACT_SUB    = 5'd15;
    localparam logic [ACT_W-1:0] ACT_MUL    = 5'd16;
    localparam logic [ACT_W-1:0] ACT_DIV_U  = 5'd17;
    localparam logic [ACT_W-1:0] ACT_REM_U  = 5'd18;
    localparam logic [ACT_W-1:0] ACT_DIV_S  = 5'd19;
    localparam logic [ACT_W-1:0] ACT_REM_S  = 5'd20;
    localparam logic [ACT_W-1:0] ACT_AND    = 5'd21;
    localparam logic [ACT_W-1:0] ACT_OR     = 5'd22;
    localparam logic [ACT_W-1:0] ACT_XOR    = 5'd23;
    localparam logic [ACT_W-1:0] ACT_SHL    = 5'd24;
    localparam logic [ACT_W-1:0] ACT_SHR_S  = 5'd25;
    localparam logic [ACT_W-1:0] ACT_SHR_U  = 5'd26;
    localparam logic [ACT_W-1:0] ACT_ROTL   = 5'd27;
    localparam logic [ACT_W-1:0] ACT_ROTR   = 5'd28;
    localparam logic [ACT_W-1:0] ACT_WRAP   = 5'd29;
    localparam logic [ACT_W-1:0] ACT_EXT_S  = 5'd30;
    localparam logic [ACT_W-1:0] ACT_EXT_U  = 5'd31;

    localparam logic [TRAP_W-1:0] TRAP_NONE = 2'd0;
    localparam logic [TRAP_W-1:0] TRAP_DIV0 = 2'd1;
    localparam logic [TRAP_W-1:0] TRAP_OVF  = 2'd2;

    localparam logic [DATA_W-1:0] LOW32_MASK  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] HIGH32_MASK = 64'hFFFF_FFFF_0000_0000;
    localparam logic [DATA_W-1:0] SIGN64      = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] SIGN32      = 64'h0000_0000_8000_0000;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ACT_W-1:0]   action;
        logic               wide;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [DATA_W-1:0]  dvd;
        logic [DATA_W-1:0]  dvs;
        logic               neg;
        logic               is_rem;
        logic               ovf;
    } item_t;

endpackage

// File: rtl/core/wia_front.sv
module wia_front
    import wia_pkg::*;
(
    input  logic [ACT_W-1:0]  action,
    input  logic              wide,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output item_t             item
);

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sign;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sa;
    logic              sb;
    logic              signed_op;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    always_comb
    begin
        mask      = wide ? '1 : LOW32_MASK;
        sign      = wide ? SIGN64 : SIGN32;
        a         = operand_a & mask;
        b         = operand_b & mask;
        sa        = (a & sign) != '0;
        sb        = (b & sign) != '0;
        mag_a     = sa ? ((~a + 64'd1) & mask) : a;
        mag_b     = sb ? ((~b + 64'd1) & mask) : b;
        signed_op = (action == ACT_DIV_S) || (action == ACT_REM_S);

        item.action = action;
        item.wide   = wide;
        item.a      = a;
        item.b      = b;
        item.dvd    = signed_op ? mag_a : a;
        item.dvs    = signed_op ? mag_b : b;
        item.is_rem = (action == ACT_REM_U) || (action == ACT_REM_S);
        item.neg    = (action == ACT_DIV_S) ? (sa ^ sb) :
                      (action == ACT_REM_S) ? sa : 1'b0;
        item.ovf    = (action == ACT_DIV_S) && (a == sign) && (b == mask);

        unique case (action) inside
            ACT_MUL:                                  item.kind = KIND_MUL;
            ACT_DIV_U, ACT_REM_U, ACT_DIV_S, ACT_REM_S: item.kind = KIND_DIV;
            default:                                  item.kind = KIND_SIMPLE;
        endcase
    end

endmodule

// File: rtl/core/wia_queue.sv
module wia_queue
    import wia_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t      slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign not_full  = cnt_reg != 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/wia_back.sv
module wia_back
    import wia_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  item_t                    q_item,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DATA_W-1:0]        out_value,
    output logic [TRAP_W-1:0]        out_trap
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] opa_reg;
    logic [DATA_W-1:0] opb_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] dq_reg;
    logic              neg_reg;
    logic              wide_reg;
    logic              rem_sel_reg;
    logic [TRAP_W-1:0] trap_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [TRAP_W-1:0] out_trap_reg;

    logic              out_free;
    logic              out_load;
    logic [DATA_W-1:0] simple_res;
    logic [DATA_W-1:0] hold_res;
    logic [DATA_W-1:0] mul_p;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] trial;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] dq_next;

    function automatic logic [6:0] popcnt64(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] s;
        s = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
        s = (s + (s >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s = s + (s >> 8);
        s = s + (s >> 16);
        s = s + (s >> 32);
        return s[6:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && q_valid &&
                       ((q_item.kind != KIND_SIMPLE) || out_free);
    assign out_load  = (pop && (q_item.kind == KIND_SIMPLE)) ||
                       ((state_reg == ST_HOLD) && out_free);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_trap  = out_trap_reg;

    always_comb
    begin
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] sign;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] as;
        logic [DATA_W-1:0] bs;
        logic [DATA_W-1:0] smear;
        logic [5:0]        sh;
        logic [6:0]        w;
        logic [6:0]        cnt;
        logic [DATA_W-1:0] r;

        mask  = q_item.wide ? '1 : LOW32_MASK;
        sign  = q_item.wide ? SIGN64 : SIGN32;
        a     = q_item.a;
        b     = q_item.b;
        as    = a ^ sign;
        bs    = b ^ sign;
        w     = q_item.wide ? 7'd64 : 7'd32;
        sh    = b[5:0] & (q_item.wide ? 6'd63 : 6'd31);
        smear = a;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        smear = smear | (smear >> 32);
        cnt   = '0;
        r     = '0;

        case (q_item.action)
            ACT_EQZ:    r = {63'd0, a == '0};
            ACT_EQ:     r = {63'd0, a == b};
            ACT_NE:     r = {63'd0, a != b};
            ACT_LT_S:   r = {63'd0, as < bs};
            ACT_GT_S:   r = {63'd0, as > bs};
            ACT_LE_S:   r = {63'd0, as <= bs};
            ACT_GE_S:   r = {63'd0, as >= bs};
            ACT_LT_U:   r = {63'd0, a < b};
            ACT_GT_U:   r = {63'd0, a > b};
            ACT_LE_U:   r = {63'd0, a <= b};
            ACT_GE_U:   r = {63'd0, a >= b};
            ACT_CLZ:
            begin
                cnt = w - popcnt64(smear);
                r   = {57'd0, cnt};
            end
            ACT_CTZ:
            begin
                cnt = popcnt64(~a & (a - 64'd1) & mask);
                r   = {57'd0, cnt};
            end
            ACT_POPCNT:
            begin
                cnt = popcnt64(a);
                r   = {57'd0, cnt};
            end
            ACT_ADD:    r = a + b;
            ACT_SUB:    r = a - b;
            ACT_AND:    r = a & b;
            ACT_OR:     r = a | b;
            ACT_XOR:    r = a ^ b;
            ACT_SHL:    r = a << sh;
            ACT_SHR_S:  r = (a >> sh) | (((a & sign) != '0) ? ~(mask >> sh) : '0);
            ACT_SHR_U:  r = a >> sh;
            ACT_ROTL:   r = (a << sh) | (a >> (w - {1'b0, sh}));
            ACT_ROTR:   r = (a >> sh) | (a << (w - {1'b0, sh}));
            ACT_WRAP:   r = a & LOW32_MASK;
            ACT_EXT_S:  r = (a & LOW32_MASK) | (a[31] ? HIGH32_MASK : '0);
            ACT_EXT_U:  r = a & LOW32_MASK;
            default:    r = '0;
        endcase

        if (q_item.action < ACT_WRAP)
        begin
            r = r & mask;
        end
        simple_res = r;
    end

    always_comb
    begin
        logic [31:0] x;
        logic [31:0] y;

        case (cnt_reg[1:0])
            2'd0:
            begin
                x = opa_reg[31:0];
                y = opb_reg[31:0];
            end
            2'd1:
            begin
                x = opa_reg[31:0];
                y = opb_reg[63:32];
            end
            default:
            begin
                x = opa_reg[63:32];
                y = opb_reg[31:0];
            end
        endcase
        mul_p    = {32'd0, x} * {32'd0, y};
        acc_next = (cnt_reg[1:0] == 2'd0) ? mul_p : acc_reg + {mul_p[31:0], 32'd0};

        shifted  = {acc_reg, dq_reg[DATA_W-1]};
        trial    = {1'b0, shifted} - {2'b00, opb_reg};
        rem_next = trial[DATA_W+1] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
        dq_next  = {dq_reg[DATA_W-2:0], ~trial[DATA_W+1]};

        hold_res = neg_reg ? (~acc_reg + 64'd1) : acc_reg;
        hold_res = hold_res & (wide_reg ? '1 : LOW32_MASK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        wide_reg    <= q_item.wide;
                        rem_sel_reg <= q_item.is_rem;
                        case (q_item.kind)
                            KIND_MUL:
                            begin
                                opa_reg   <= q_item.a;
                                opb_reg   <= q_item.b;
                                neg_reg   <= 1'b0;
                                trap_reg  <= TRAP_NONE;
                                cnt_reg   <= '0;
                                state_reg <= ST_MUL;
                            end
                            KIND_DIV:
                            begin
                                if (q_item.dvs == '0 || q_item.ovf)
                                begin
                                    acc_reg   <= '0;
                                    neg_reg   <= 1'b0;
                                    trap_reg  <= q_item.ovf ? TRAP_OVF : TRAP_DIV0;
                                    state_reg <= ST_HOLD;
                                end
                                else
                                begin
                                    acc_reg   <= '0;
                                    neg_reg   <= q_item.neg;
                                    opb_reg   <= q_item.dvs;
                                    dq_reg    <= q_item.wide ? q_item.dvd :
                                                 {q_item.dvd[31:0], 32'd0};
                                    cnt_reg   <= q_item.wide ? 7'd64 : 7'd32;
                                    trap_reg  <= TRAP_NONE;
                                    state_reg <= ST_DIV;
                                end
                            end
                            default:
                            begin
                                out_value_reg <= simple_res;
                                out_trap_reg  <= TRAP_NONE;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[1:0] == 2'd2)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_DIV:
                begin
                    dq_reg  <= dq_next;
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        acc_reg   <= rem_sel_reg ? rem_next : dq_next;
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        acc_reg <= rem_next;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_value_reg <= hold_res;
                        out_trap_reg  <= trap_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_trap_reg != TRAP_NONE) |-> out_value_reg == '0)
        else $error("trapped result carries a nonzero value");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("request taken from queue while unit busy");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0) && (cnt_reg <= 7'd64))
        else $error("divide step count out of range");

    a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) && out_free |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule

// File: rtl/core/wasm_integer_alu_core.sv
// Channel   Direction  Fields in tdata (lowest bit first)
// s_axis    in         action[4:0], wide[5], operand_a[69:6], operand_b[133:70], zero pad
// m_axis    out        result_value[63:0], trap_code[65:64], zero pad
//
// Compare, count, logic, shift, add and conversion requests are computed at once and
// follow back to back while the output is free. A multiply holds the execute unit for
// three 32-bit partial products and a hold state that presents the result, a divide
// or remainder for one quotient bit per cycle and then the hold state, and a trapping
// divide for the hold state alone. A two-entry queue lets the input accept while the
// execute unit or the output stalls. Reset clears the queue and the output valid flag.
module wasm_integer_alu_core
    import wia_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action, wide, operand_a, operand_b
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value, trap_code
    output logic [71:0]  m_axis_tdata
);

    item_t             front_item;
    item_t             head_item;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;
    logic [DATA_W-1:0] res_value;
    logic [TRAP_W-1:0] res_trap;

    assign s_axis_tready = q_not_full;
    assign m_axis_tdata  = {6'd0, res_trap, res_value};

    wia_front u_front (
        .action    (s_axis_tdata[4:0]),
        .wide      (s_axis_tdata[5]),
        .operand_a (s_axis_tdata[69:6]),
        .operand_b (s_axis_tdata[133:70]),
        .item      (front_item)
    );

    wia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && q_not_full),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    wia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (head_item),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (res_value),
        .out_trap  (res_trap)
    );

endmodule
